// ===== src/sis_pkg.sv =====
package sis_pkg;

    // position field width fixed by the result format
    localparam int unsigned POS_W = 6;
    localparam int unsigned IN_KEY_W = 32;

    typedef struct packed {
        logic signed [IN_KEY_W-1:0] key;
        logic                       is_last;
    } sis_in_t;

    typedef struct packed {
        logic [POS_W-1:0] sorted_position;
        logic             overflow;
        logic             final_res;
    } sis_out_t;

    // controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;   // insert the broadcast key this cycle
        logic shift;  // move every cell one place toward the head
    } sis_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } sis_state_t;

endpackage

// ===== src/stable_index_sorter_core.sv =====
// order: a key is inserted in the cycle it is accepted; results start the cycle after
//   the beat marked last, then one result per cycle while out_ready is high
// throughput: one key per cycle while loading; every held key is first loaded, then drained,
//   and input stalls while the run drains from the chain head
// reset (rst_n, async, active low): chain empty, arrival count and drop flag cleared,
//   block ready for a new list
module stable_index_sorter_core #(
    parameter int unsigned MAX_LEN   = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sis_pkg::sis_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sis_pkg::sis_out_t out_data
);
    import sis_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

    sis_state_t state_reg;
    sis_state_t state_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic dropped_reg;
    logic dropped_next;

    sis_ctrl_t ctrl;

    logic in_beat;
    logic out_beat;
    logic chain_full;

    // broadcast key: field sign-extended, then cut to the stored width
    logic signed [63:0]          key_ext;
    logic signed [KEY_WIDTH-1:0] bcast_key;
    logic [POS_W-1:0]            bcast_pos;

    // chain taps, one per cell
    logic                        c_valid [MAX_LEN];
    logic                        c_ins   [MAX_LEN];
    logic signed [KEY_WIDTH-1:0] c_key   [MAX_LEN];
    logic [POS_W-1:0]            c_pos   [MAX_LEN];

    assign key_ext   = 64'(in_data.key);
    assign bcast_key = key_ext[KEY_WIDTH-1:0];
    assign bcast_pos = POS_W'(fill_reg);

    assign in_beat    = in_valid && in_ready;
    assign out_beat   = out_valid && out_ready;
    assign chain_full = c_valid[MAX_LEN-1];

    // insertion chain: each cell compares the broadcast key against its own and
    // takes either the key, its left neighbor's entry, or keeps its own;
    // during drain every cell takes its right neighbor's entry
    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        logic                        lv;
        logic                        li;
        logic signed [KEY_WIDTH-1:0] lk;
        logic [POS_W-1:0]            lp;
        logic                        rv;
        logic signed [KEY_WIDTH-1:0] rk;
        logic [POS_W-1:0]            rp;

        if (i == 0)
        begin : g_head
            assign lv = 1'b1;
            assign li = 1'b0;
            assign lk = '0;
            assign lp = '0;
        end
        else
        begin : g_body
            assign lv = c_valid[i-1];
            assign li = c_ins[i-1];
            assign lk = c_key[i-1];
            assign lp = c_pos[i-1];
        end

        if (i == MAX_LEN - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rk = '0;
            assign rp = '0;
        end
        else
        begin : g_next
            assign rv = c_valid[i+1];
            assign rk = c_key[i+1];
            assign rp = c_pos[i+1];
        end

        sis_cell #(
            .KEY_WIDTH(KEY_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_key    (bcast_key),
            .new_pos    (bcast_pos),
            .left_valid (lv),
            .left_ins   (li),
            .left_key   (lk),
            .left_pos   (lp),
            .right_valid(rv),
            .right_key  (rk),
            .right_pos  (rp),
            .valid      (c_valid[i]),
            .ins        (c_ins[i]),
            .key        (c_key[i]),
            .pos        (c_pos[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        ctrl.load    = 1'b0;
        ctrl.shift   = 1'b0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_beat)
                begin
                    if (chain_full)
                    begin
                        // extra key dropped, arrival count holds
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.load = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    if (in_data.is_last)
                    begin
                        fill_next  = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_beat)
                begin
                    ctrl.shift = 1'b1;
                    if (!c_valid[1])
                    begin
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    // head of the chain is the output register
    assign out_data.sorted_position = c_pos[0];
    assign out_data.overflow        = dropped_reg;
    assign out_data.final_res       = !c_valid[1];

    // a result beat always comes from an occupied head cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> c_valid[0])
        else $error("result offered from empty chain head");

    // the two sides never run at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("load and drain active together");

    // arrival count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_LEN))
        else $error("arrival count beyond capacity");

    // after the final result the chain is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && out_data.final_res) |=> (!c_valid[0] && !dropped_reg && in_ready))
        else $error("chain not cleared after final result");

endmodule

// ===== src/sis_cell.sv =====
module sis_cell #(
    parameter int unsigned KEY_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sis_pkg::sis_ctrl_t          ctrl,
    input  logic signed [KEY_WIDTH-1:0] new_key,
    input  logic [sis_pkg::POS_W-1:0]   new_pos,
    input  logic                        left_valid,
    input  logic                        left_ins,
    input  logic signed [KEY_WIDTH-1:0] left_key,
    input  logic [sis_pkg::POS_W-1:0]   left_pos,
    input  logic                        right_valid,
    input  logic signed [KEY_WIDTH-1:0] right_key,
    input  logic [sis_pkg::POS_W-1:0]   right_pos,
    output logic                        valid,
    output logic                        ins,
    output logic signed [KEY_WIDTH-1:0] key,
    output logic [sis_pkg::POS_W-1:0]   pos
);
    import sis_pkg::*;

    logic                        valid_reg;
    logic                        valid_next;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;

    // empty cell counts as +infinity; strict less keeps equal keys in order
    assign ins = !valid_reg || (new_key < key_reg);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        priority if (ctrl.shift)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            pos_next   = right_pos;
        end
        else if (ctrl.load && ins)
        begin
            valid_next = valid_reg || left_valid;
            if (left_ins)
            begin
                key_next = left_key;
                pos_next = left_pos;
            end
            else
            begin
                key_next = new_key;
                pos_next = new_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign pos   = pos_reg;

endmodule
